### src/tqwls_pkg.sv
// Shared types and constants for the two-queue weighted lottery scheduler.
`default_nettype none
package tqwls_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int RAM_DEPTH   = 2 * (2 ** QIDX_W);

   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TIME   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_SHARE = 1'd1;

   localparam logic [15:0] MAX_TIME_RESET   = 16'd1000;
   localparam logic [6:0]  LONG_SHARE_RESET = 7'd70;

   localparam logic [1:0] STATE_READY    = 2'd0;
   localparam logic [1:0] STATE_BLOCKED  = 2'd1;
   localparam logic [1:0] STATE_FINISHED = 2'd2;
   localparam logic [1:0] STATE_INVALID  = 2'd3;

   localparam logic [2:0] DEST_LONG     = 3'd0;
   localparam logic [2:0] DEST_SHORT    = 3'd1;
   localparam logic [2:0] DEST_BLOCKED  = 3'd2;
   localparam logic [2:0] DEST_FINISHED = 3'd3;
   localparam logic [2:0] DEST_INVALID  = 3'd4;
   localparam logic [2:0] DEST_NONE     = 3'd5;

   localparam logic QUEUE_LONG  = 1'b0;
   localparam logic QUEUE_SHORT = 1'b1;

   typedef struct packed {
      logic        has_current;
      logic [7:0]  current_id;
      logic [15:0] current_total_time;
      logic [1:0]  current_state;
      logic [6:0]  random_pct;
   } req_type;

   typedef struct packed {
      logic [2:0] current_dest;
      logic       overflow;
      logic       selected_valid;
      logic [7:0] selected_id;
      logic       selected_queue;
   } rsp_type;

endpackage
`default_nettype wire

### src/tqwls_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module tqwls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### src/two_queue_weighted_lottery_scheduler.sv
// Each accepted word goes through these steps: accept it, classify the outgoing
// process and push it into its ready queue, draw a queue and read the head id
// from the shared id memory, and load the result register. The steps run in
// order through the single memory, so no new word is taken before the last is loaded;
// a new word is accepted even while a finished result still waits in the output
// register, and only the load step waits for that register.
// Both ready queues live in one memory, the long queue in the lower half and the short
// queue in the upper half; heads and fill counts sit in flip-flops cleared by reset.
`default_nettype none
module two_queue_weighted_lottery_scheduler
   import tqwls_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PUSH = 2'd1;
   localparam logic [1:0] S_PICK = 2'd2;
   localparam logic [1:0] S_LOAD = 2'd3;

   localparam logic [QIDX_W:0]   DEPTH_SUM = (QIDX_W + 1)'(QUEUE_DEPTH);
   localparam logic [QIDX_W-1:0] LAST_IDX  = QIDX_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] FULL_CNT  = QCNT_W'(QUEUE_DEPTH);
   localparam int                ADDR_W    = QIDX_W + 1;

   logic [1:0]        state_ff, state_in;
   logic [15:0]       max_time_ff, max_time_in;
   logic [6:0]        share_ff, share_in;
   logic [QIDX_W-1:0] long_head_ff, long_head_in, short_head_ff, short_head_in;
   logic [QCNT_W-1:0] long_cnt_ff, long_cnt_in, short_cnt_ff, short_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   req_type           req_ff;
   logic [2:0]        dest_ff, dest_in;
   logic              ovf_ff, ovf_in;
   logic              sel_valid_ff, sel_valid_in;
   logic              sel_queue_ff, sel_queue_in;
   rsp_type           rsp_ff, rsp_in;

   logic              req_take;
   logic              out_free;

   // Push step signals.
   logic [19:0]       time_x10;
   logic [19:0]       budget_x3;
   logic              is_long;
   logic [QIDX_W-1:0] tgt_head;
   logic [QCNT_W-1:0] tgt_cnt;
   logic              tgt_full;
   logic              do_push;
   logic [QIDX_W:0]   tail_sum;
   logic [QIDX_W-1:0] tail_idx;

   // Pick step signals.
   logic              any_ready;
   logic              want_long;
   logic              use_long;
   logic [QIDX_W-1:0] pop_head;
   logic [QIDX_W-1:0] pop_head_next;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // The class test 10*t > 3*max is done with shifts and adds.
   assign time_x10  = {1'b0, req_ff.current_total_time, 3'b000}
                    + {3'b000, req_ff.current_total_time, 1'b0};
   assign budget_x3 = {3'b000, max_time_ff, 1'b0} + {4'b0000, max_time_ff};
   assign is_long   = time_x10 > budget_x3;

   assign tgt_head  = is_long ? long_head_ff : short_head_ff;
   assign tgt_cnt   = is_long ? long_cnt_ff : short_cnt_ff;
   assign tgt_full  = (tgt_cnt == FULL_CNT);
   assign do_push   = (state_ff == S_PUSH) && req_ff.has_current
                    && (req_ff.current_state == STATE_READY) && !tgt_full;
   assign tail_sum  = {1'b0, tgt_head} + {1'b0, tgt_cnt[QIDX_W-1:0]};
   assign tail_idx  = (tail_sum >= DEPTH_SUM) ? QIDX_W'(tail_sum - DEPTH_SUM)
                                              : tail_sum[QIDX_W-1:0];

   assign any_ready     = (long_cnt_ff != '0) || (short_cnt_ff != '0);
   assign want_long     = req_ff.random_pct < share_ff;
   assign use_long      = want_long ? (long_cnt_ff != '0) : (short_cnt_ff == '0);
   assign pop_head      = use_long ? long_head_ff : short_head_ff;
   assign pop_head_next = (pop_head == LAST_IDX) ? '0 : pop_head + 1'b1;

   assign ram_wr_en   = do_push;
   assign ram_wr_addr = {(is_long ? QUEUE_LONG : QUEUE_SHORT), tail_idx};
   assign ram_rd_en   = (state_ff == S_PICK) && any_ready;
   assign ram_rd_addr = {(use_long ? QUEUE_LONG : QUEUE_SHORT), pop_head};

   tqwls_ram #(
      .WIDTH(8),
      .DEPTH(RAM_DEPTH)
   ) u_id_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(req_ff.current_id),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      max_time_in   = max_time_ff;
      share_in      = share_ff;
      long_head_in  = long_head_ff;
      long_cnt_in   = long_cnt_ff;
      short_head_in = short_head_ff;
      short_cnt_in  = short_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      dest_in       = dest_ff;
      ovf_in        = ovf_ff;
      sel_valid_in  = sel_valid_ff;
      sel_queue_in  = sel_queue_ff;
      rsp_in        = rsp_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_TIME:   max_time_in = csr_wdata;
            CSR_LONG_SHARE: share_in    = csr_wdata[6:0];
            default:        ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            ovf_in = 1'b0;
            if (!req_ff.has_current) begin
               dest_in = DEST_NONE;
            end else begin
               unique case (req_ff.current_state)
                  STATE_READY: begin
                     dest_in = is_long ? DEST_LONG : DEST_SHORT;
                     ovf_in  = tgt_full;
                  end
                  STATE_BLOCKED:  dest_in = DEST_BLOCKED;
                  STATE_FINISHED: dest_in = DEST_FINISHED;
                  STATE_INVALID:  dest_in = DEST_INVALID;
                  default:        dest_in = DEST_INVALID;
               endcase
            end
            if (do_push) begin
               if (is_long) begin
                  long_cnt_in = long_cnt_ff + 1'b1;
               end else begin
                  short_cnt_in = short_cnt_ff + 1'b1;
               end
            end
            state_in = S_PICK;
         end
         S_PICK: begin
            sel_valid_in = any_ready;
            sel_queue_in = QUEUE_LONG;
            if (any_ready) begin
               if (use_long) begin
                  long_head_in = pop_head_next;
                  long_cnt_in  = long_cnt_ff - 1'b1;
               end else begin
                  short_head_in = pop_head_next;
                  short_cnt_in  = short_cnt_ff - 1'b1;
                  sel_queue_in  = QUEUE_SHORT;
               end
            end
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (out_free) begin
               rsp_in.current_dest   = dest_ff;
               rsp_in.overflow       = ovf_ff;
               rsp_in.selected_valid = sel_valid_ff;
               rsp_in.selected_id    = sel_valid_ff ? ram_rd_data : 8'd0;
               rsp_in.selected_queue = sel_queue_ff;
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         max_time_ff   <= MAX_TIME_RESET;
         share_ff      <= LONG_SHARE_RESET;
         long_head_ff  <= '0;
         long_cnt_ff   <= '0;
         short_head_ff <= '0;
         short_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         max_time_ff   <= max_time_in;
         share_ff      <= share_in;
         long_head_ff  <= long_head_in;
         long_cnt_ff   <= long_cnt_in;
         short_head_ff <= short_head_in;
         short_cnt_ff  <= short_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      dest_ff      <= dest_in;
      ovf_ff       <= ovf_in;
      sel_valid_ff <= sel_valid_in;
      sel_queue_ff <= sel_queue_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

### src/tqwls_checker.sv
// Port-level checks for the two-queue weighted lottery scheduler, bound to the top level.
`default_nettype none
module tqwls_checker
   import tqwls_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // A result that is held back stays in place until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed or vanished");

   // No word can be pending right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // An empty draw reports id zero from the long queue.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.selected_valid |->
         rsp_data.selected_id == 8'd0 && rsp_data.selected_queue == QUEUE_LONG)
      else $error("empty draw carries a nonzero id or queue");

   // Only a ready process can overflow a queue.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |->
         rsp_data.current_dest == DEST_LONG || rsp_data.current_dest == DEST_SHORT)
      else $error("overflow reported for a process that was not queued");

   // The input side is not offered while the engine is busy, so words cannot be
   // accepted back to back.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted on back-to-back cycles");

endmodule

bind two_queue_weighted_lottery_scheduler tqwls_checker u_tqwls_checker (.*);
`default_nettype wire
